@@ rtl/line_follow_pid_step_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the line follower PID step block
// Each macro expands to a clocked, reset-gated concurrent assertion in
// simulation and to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PID_STEP_MACROS_SVH
`define LINE_FOLLOW_PID_STEP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define LFP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define LFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LFP_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define LFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/lfp_pkg.sv @@
// ---------------------------------------------------------------------------
// Line follower PID step package
// Shared widths, constants, codes and the structs passed between stages.
// ---------------------------------------------------------------------------
package lfp_pkg;

  // Sensor array and field widths.
  localparam int SENSOR_COUNT = 8;
  localparam int READING_W    = 10;
  localparam int POS_W        = 13;
  localparam int ERR_W        = 13;
  localparam int DIFF_W       = ERR_W + 1;
  localparam int SUM_W        = 32;
  localparam int TIME_W       = 32;
  localparam int HOLD_W       = 16;
  localparam int GAIN_W       = 20;
  localparam int SPEED_W      = 8;
  localparam int DRIVE_W      = SPEED_W + 1;

  // Products of an unsigned gain (with a zero sign bit) and a signed term.
  localparam int P_KP_W = GAIN_W + 1 + ERR_W;
  localparam int P_KD_W = GAIN_W + 1 + DIFF_W;
  localparam int P_KI_W = GAIN_W + 1 + SUM_W;
  localparam int ACC_W  = P_KI_W + 1;

  // Line position range.
  localparam int POS_MAX    = (SENSOR_COUNT - 1) * 1000;
  localparam int POS_CENTRE = (SENSOR_COUNT - 1) * 500;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = GAIN_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KP_GAIN        = 3'd0,
    REG_KI_GAIN        = 3'd1,
    REG_KD_GAIN        = 3'd2,
    REG_BASE_SPEED     = 3'd3,
    REG_TURN_SPEED     = 3'd4,
    REG_DARK_LEVEL     = 3'd5,
    REG_SIDE_THRESHOLD = 3'd6,
    REG_SIDE_HOLD_MS   = 3'd7
  } cfg_reg_t;

  // Register values after reset.
  localparam logic [GAIN_W-1:0]    RST_KP_GAIN        = 20'd7852;
  localparam logic [GAIN_W-1:0]    RST_KI_GAIN        = 20'd655;
  localparam logic [GAIN_W-1:0]    RST_KD_GAIN        = 20'd69406;
  localparam logic [SPEED_W-1:0]   RST_BASE_SPEED     = 8'd125;
  localparam logic [SPEED_W-1:0]   RST_TURN_SPEED     = 8'd120;
  localparam logic [READING_W-1:0] RST_DARK_LEVEL     = 10'd750;
  localparam logic [READING_W-1:0] RST_SIDE_THRESHOLD = 10'd800;
  localparam logic [HOLD_W-1:0]    RST_SIDE_HOLD_MS   = 16'd100;

  // Run command codes; any other code keeps the current run state.
  localparam logic [1:0] CMD_STOP = 2'd0;
  localparam logic [1:0] CMD_RUN  = 2'd1;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_t;

  typedef logic [SENSOR_COUNT-1:0][READING_W-1:0] readings_t;

  typedef struct packed {
    logic [GAIN_W-1:0]    kp_gain;
    logic [GAIN_W-1:0]    ki_gain;
    logic [GAIN_W-1:0]    kd_gain;
    logic [SPEED_W-1:0]   base_speed;
    logic [SPEED_W-1:0]   turn_speed;
    logic [READING_W-1:0] dark_level;
    logic [READING_W-1:0] side_threshold;
    logic [HOLD_W-1:0]    side_hold_ms;
  } lfp_cfg_t;

  // Register load strobes, one for each pipeline stage.
  typedef struct packed {
    logic in;
    logic step;
    logic mul;
    logic acc;
    logic corr;
    logic out;
  } lfp_load_t;

  // Per-beat facts that ride alongside the arithmetic.
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic                    lost;
    side_t                   side;
    logic                    running;
  } lfp_tag_t;

  typedef struct packed {
    lfp_tag_t                 tag;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  sum;
  } lfp_step_t;

endpackage

@@ rtl/lfp_state.sv @@
// ---------------------------------------------------------------------------
// Line follower state step
// Registers the incoming beat, then advances the run flag, remembered side,
// integral sum and previous error, and forms the line error and its change.
// ---------------------------------------------------------------------------
`include "line_follow_pid_step_macros.svh"

module lfp_state (
  input  logic                                     clk,
  input  logic                                     rst,
  input  lfp_pkg::lfp_load_t                       load,
  input  lfp_pkg::lfp_cfg_t                        cfg,
  input  logic [lfp_pkg::POS_W-1:0]                position,
  input  lfp_pkg::readings_t                       readings,
  input  logic [lfp_pkg::TIME_W-1:0]               now_ms,
  input  logic [1:0]                               cmd,
  output lfp_pkg::lfp_step_t                       step
);

  // Input register.
  logic [lfp_pkg::POS_W-1:0]  pos_q;
  lfp_pkg::readings_t         rd_q;
  logic [lfp_pkg::TIME_W-1:0] now_q;
  logic [1:0]                 cmd_q;

  // Controller state; prev_error doubles as this beat's error downstream.
  logic                                running;
  lfp_pkg::side_t                      side_seen;
  logic [lfp_pkg::TIME_W-1:0]          side_time;
  logic signed [lfp_pkg::SUM_W-1:0]    error_sum;
  logic signed [lfp_pkg::ERR_W-1:0]    prev_error;
  logic signed [lfp_pkg::DIFF_W-1:0]   diff_q;
  logic                                lost_q;

  logic                                running_next;
  lfp_pkg::side_t                      side_next;
  logic [lfp_pkg::TIME_W-1:0]          side_time_next;
  logic signed [lfp_pkg::SUM_W-1:0]    error_sum_next;
  logic signed [lfp_pkg::ERR_W-1:0]    err;
  logic signed [lfp_pkg::DIFF_W-1:0]   diff_next;
  logic                                lost_next;

  logic [lfp_pkg::POS_W-1:0]           pos_sat;
  logic signed [lfp_pkg::DIFF_W-1:0]   err_wide;
  logic signed [lfp_pkg::SUM_W-1:0]    sum_base;
  logic signed [lfp_pkg::SUM_W:0]      sum_wide;
  logic [lfp_pkg::TIME_W-1:0]          elapsed;
  logic                                hold_done;
  logic                                want_left;
  logic                                want_right;

  always_ff @(posedge clk) begin
    if (load.in) begin
      pos_q <= position;
      rd_q  <= readings;
      now_q <= now_ms;
      cmd_q <= cmd;
    end
  end

  // Run command: run also restarts the integral.
  always_comb begin
    running_next = running;
    sum_base     = error_sum;
    priority if (cmd_q == lfp_pkg::CMD_RUN) begin
      running_next = 1'b1;
      sum_base     = '0;
    end else if (cmd_q == lfp_pkg::CMD_STOP) begin
      running_next = 1'b0;
    end else begin
      running_next = running;
    end
  end

  // Remembered side, changed only after the hold time has passed.
  always_comb begin
    want_left      = (rd_q[0] >= cfg.side_threshold) &&
                     (rd_q[lfp_pkg::SENSOR_COUNT-1] < cfg.side_threshold);
    want_right     = (rd_q[0] < cfg.side_threshold) &&
                     (rd_q[lfp_pkg::SENSOR_COUNT-1] >= cfg.side_threshold);
    elapsed        = now_q - side_time;
    hold_done      = elapsed >= lfp_pkg::TIME_W'(cfg.side_hold_ms);
    side_next      = side_seen;
    side_time_next = side_time;
    if (want_left && side_seen != lfp_pkg::SIDE_LEFT && hold_done) begin
      side_next      = lfp_pkg::SIDE_LEFT;
      side_time_next = now_q;
    end else if (want_right && side_seen != lfp_pkg::SIDE_RIGHT && hold_done) begin
      side_next      = lfp_pkg::SIDE_RIGHT;
      side_time_next = now_q;
    end
  end

  // The line is lost when no sensor reads above the threshold.
  always_comb begin
    lost_next = 1'b1;
    for (int i = 0; i < lfp_pkg::SENSOR_COUNT; i++) begin
      if (rd_q[i] > cfg.dark_level) begin
        lost_next = 1'b0;
      end
    end
  end

  // Error, its change since the last beat, and the saturating integral.
  always_comb begin
    pos_sat   = (pos_q > lfp_pkg::POS_W'(lfp_pkg::POS_MAX)) ?
                lfp_pkg::POS_W'(lfp_pkg::POS_MAX) : pos_q;
    err_wide  = signed'({1'b0, pos_sat}) - lfp_pkg::DIFF_W'(lfp_pkg::POS_CENTRE);
    err       = err_wide[lfp_pkg::ERR_W-1:0];
    diff_next = lfp_pkg::DIFF_W'(err) - lfp_pkg::DIFF_W'(prev_error);
    sum_wide  = (lfp_pkg::SUM_W+1)'(sum_base) + (lfp_pkg::SUM_W+1)'(err);
    if (sum_wide[lfp_pkg::SUM_W] != sum_wide[lfp_pkg::SUM_W-1]) begin
      error_sum_next = sum_wide[lfp_pkg::SUM_W] ?
                       {1'b1, {(lfp_pkg::SUM_W-1){1'b0}}} :
                       {1'b0, {(lfp_pkg::SUM_W-1){1'b1}}};
    end else begin
      error_sum_next = sum_wide[lfp_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      side_seen  <= lfp_pkg::SIDE_NONE;
      side_time  <= '0;
      error_sum  <= '0;
      prev_error <= '0;
    end else if (load.step) begin
      running    <= running_next;
      side_seen  <= side_next;
      side_time  <= side_time_next;
      error_sum  <= error_sum_next;
      prev_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (load.step) begin
      diff_q <= diff_next;
      lost_q <= lost_next;
    end
  end

  assign step.tag.err     = prev_error;
  assign step.tag.lost    = lost_q;
  assign step.tag.side    = side_seen;
  assign step.tag.running = running;
  assign step.diff        = diff_q;
  assign step.sum         = error_sum;

  // The integral moves only when a beat passes through this stage.
  `LFP_ASSERT_NEXT(a_sum_held, clk, rst, !load.step, $stable(error_sum), "integral moved without a beat")
  // The stored error stays inside the centred position range.
  `LFP_ASSERT_IMPL(a_err_range, clk, rst, 1'b1, prev_error >= -13'sd3500 && prev_error <= 13'sd3500, "line error out of range")

endmodule

@@ rtl/lfp_pid.sv @@
// ---------------------------------------------------------------------------
// Line follower PID correction
// Three gain products, their sum, and a shift of the sum toward zero, one
// register stage each.
// ---------------------------------------------------------------------------
module lfp_pid #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                                clk,
  input  lfp_pkg::lfp_load_t                                  load,
  input  lfp_pkg::lfp_cfg_t                                   cfg,
  input  lfp_pkg::lfp_step_t                                  step,
  output logic signed [lfp_pkg::ACC_W-GAIN_FRAC_BITS-1:0]     corr,
  output lfp_pkg::lfp_tag_t                                   tag
);

  localparam int ACC_W  = lfp_pkg::ACC_W;
  localparam int CORR_W = ACC_W - GAIN_FRAC_BITS;
  localparam logic [ACC_W-1:0] ROUND_MASK = (ACC_W'(1) << GAIN_FRAC_BITS) - ACC_W'(1);

  logic signed [lfp_pkg::GAIN_W:0]   kp_s;
  logic signed [lfp_pkg::GAIN_W:0]   ki_s;
  logic signed [lfp_pkg::GAIN_W:0]   kd_s;

  logic signed [lfp_pkg::P_KP_W-1:0] p_kp;
  logic signed [lfp_pkg::P_KD_W-1:0] p_kd;
  logic signed [lfp_pkg::P_KI_W-1:0] p_ki;
  lfp_pkg::lfp_tag_t                 tag_mul;

  logic signed [ACC_W-1:0]           acc;
  lfp_pkg::lfp_tag_t                 tag_acc;

  logic [ACC_W-1:0]                  biased;

  assign kp_s = signed'({1'b0, cfg.kp_gain});
  assign ki_s = signed'({1'b0, cfg.ki_gain});
  assign kd_s = signed'({1'b0, cfg.kd_gain});

  // Gain products.
  always_ff @(posedge clk) begin
    if (load.mul) begin
      p_kp    <= kp_s * step.tag.err;
      p_kd    <= kd_s * step.diff;
      p_ki    <= ki_s * step.sum;
      tag_mul <= step.tag;
    end
  end

  // Exact sum of the three terms.
  always_ff @(posedge clk) begin
    if (load.acc) begin
      acc     <= ACC_W'(p_kp) + ACC_W'(p_kd) + ACC_W'(p_ki);
      tag_acc <= tag_mul;
    end
  end

  // Shift out the fraction; a negative sum is biased so it truncates toward zero.
  assign biased = acc + (acc[ACC_W-1] ? ROUND_MASK : '0);

  always_ff @(posedge clk) begin
    if (load.corr) begin
      corr <= CORR_W'(biased[ACC_W-1:GAIN_FRAC_BITS]);
      tag  <= tag_acc;
    end
  end

endmodule

@@ rtl/lfp_drive.sv @@
// ---------------------------------------------------------------------------
// Line follower wheel drive
// Clamps base speed minus and plus the correction, overrides with a spin
// toward the remembered side or with zero, and holds the result register.
// ---------------------------------------------------------------------------
module lfp_drive #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                              clk,
  input  lfp_pkg::lfp_load_t                                load,
  input  lfp_pkg::lfp_cfg_t                                 cfg,
  input  logic signed [lfp_pkg::ACC_W-GAIN_FRAC_BITS-1:0]   corr,
  input  lfp_pkg::lfp_tag_t                                 tag,
  output logic signed [lfp_pkg::DRIVE_W-1:0]                left_drive,
  output logic signed [lfp_pkg::DRIVE_W-1:0]                right_drive,
  output logic                                              line_lost,
  output logic [1:0]                                        seen_side,
  output logic signed [lfp_pkg::ERR_W-1:0]                  line_error
);

  localparam int CORR_W  = lfp_pkg::ACC_W - GAIN_FRAC_BITS;
  localparam int SPEED_W = lfp_pkg::SPEED_W;
  localparam int DRIVE_W = lfp_pkg::DRIVE_W;

  logic signed [CORR_W-1:0]  base_ext;
  logic [SPEED_W-1:0]        left_pid;
  logic [SPEED_W-1:0]        right_pid;
  logic signed [DRIVE_W-1:0] turn_pos;
  logic signed [DRIVE_W-1:0] turn_neg;
  logic signed [DRIVE_W-1:0] left_next;
  logic signed [DRIVE_W-1:0] right_next;

  assign base_ext = signed'(CORR_W'(cfg.base_speed));
  assign turn_pos = signed'({1'b0, cfg.turn_speed});
  assign turn_neg = -turn_pos;

  // Each wheel stays within zero and the base speed.
  always_comb begin
    if (corr <= 0) begin
      left_pid = cfg.base_speed;
    end else if (corr >= base_ext) begin
      left_pid = '0;
    end else begin
      left_pid = cfg.base_speed - corr[SPEED_W-1:0];
    end
    if (corr >= 0) begin
      right_pid = cfg.base_speed;
    end else if (corr <= -base_ext) begin
      right_pid = '0;
    end else begin
      right_pid = cfg.base_speed + corr[SPEED_W-1:0];
    end
  end

  // Stop, spin back toward a lost line, or follow.
  always_comb begin
    priority if (!tag.running) begin
      left_next  = '0;
      right_next = '0;
    end else if (tag.lost && tag.side == lfp_pkg::SIDE_RIGHT) begin
      left_next  = turn_neg;
      right_next = turn_pos;
    end else if (tag.lost && tag.side == lfp_pkg::SIDE_LEFT) begin
      left_next  = turn_pos;
      right_next = turn_neg;
    end else begin
      left_next  = signed'({1'b0, left_pid});
      right_next = signed'({1'b0, right_pid});
    end
  end

  always_ff @(posedge clk) begin
    if (load.out) begin
      left_drive  <= left_next;
      right_drive <= right_next;
      line_lost   <= tag.lost;
      seen_side   <= tag.side;
      line_error  <= tag.err;
    end
  end

endmodule

@@ rtl/line_follow_pid_step.sv @@
// ---------------------------------------------------------------------------
// Line follower PID step
// One control tick per beat: line error, saturating integral, PID
// correction and the two wheel drives, in a six-stage registered pipeline.
// ---------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  item     in         item_valid/item_stall  position, sensor_0..7, now_ms, cmd
//  result   out        result_valid/result_stall
//                                             left_drive, right_drive, line_lost,
//                                             seen_side, line_error
//  cfg      in         cfg_write              cfg_index, cfg_data
//
// A beat taken into the input register reaches the result register through
// the six register stages (input, state, gain products, sum, shift, result).
// One beat is taken every cycle unless item_stall is high. The
// controller state advances in the second stage, so every beat sees the
// state left by the one before it.
// Reset clears the state, the stage valid bits and the configuration
// registers to their documented values. A result stall holds the result register and lets the
// stages behind it fill; item_stall rises only when every stage is full.
// ---------------------------------------------------------------------------
`include "line_follow_pid_step_macros.svh"

module line_follow_pid_step #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [lfp_pkg::POS_W-1:0]             position,
  input  logic [lfp_pkg::READING_W-1:0]         sensor_0,
  input  logic [lfp_pkg::READING_W-1:0]         sensor_1,
  input  logic [lfp_pkg::READING_W-1:0]         sensor_2,
  input  logic [lfp_pkg::READING_W-1:0]         sensor_3,
  input  logic [lfp_pkg::READING_W-1:0]         sensor_4,
  input  logic [lfp_pkg::READING_W-1:0]         sensor_5,
  input  logic [lfp_pkg::READING_W-1:0]         sensor_6,
  input  logic [lfp_pkg::READING_W-1:0]         sensor_7,
  input  logic [lfp_pkg::TIME_W-1:0]            now_ms,
  input  logic [1:0]                            cmd,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [lfp_pkg::DRIVE_W-1:0]    left_drive,
  output logic signed [lfp_pkg::DRIVE_W-1:0]    right_drive,
  output logic                                  line_lost,
  output logic [1:0]                            seen_side,
  output logic signed [lfp_pkg::ERR_W-1:0]      line_error,
  input  logic                                  cfg_write,
  input  logic [lfp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [lfp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int STAGES = 6;
  localparam int CORR_W = lfp_pkg::ACC_W - GAIN_FRAC_BITS;

  lfp_pkg::lfp_cfg_t         cfg;
  lfp_pkg::lfp_load_t        load;
  lfp_pkg::readings_t        readings;
  lfp_pkg::lfp_step_t        step;
  lfp_pkg::lfp_tag_t         tag;
  logic signed [CORR_W-1:0]  corr;

  logic [STAGES-1:0]         stage_valid;
  logic [STAGES-1:0]         ready;
  logic [STAGES-1:0]         upstream;
  logic [STAGES-1:0]         load_vec;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain        <= lfp_pkg::RST_KP_GAIN;
      cfg.ki_gain        <= lfp_pkg::RST_KI_GAIN;
      cfg.kd_gain        <= lfp_pkg::RST_KD_GAIN;
      cfg.base_speed     <= lfp_pkg::RST_BASE_SPEED;
      cfg.turn_speed     <= lfp_pkg::RST_TURN_SPEED;
      cfg.dark_level     <= lfp_pkg::RST_DARK_LEVEL;
      cfg.side_threshold <= lfp_pkg::RST_SIDE_THRESHOLD;
      cfg.side_hold_ms   <= lfp_pkg::RST_SIDE_HOLD_MS;
    end else if (cfg_write) begin
      unique case (lfp_pkg::cfg_reg_t'(cfg_index))
        lfp_pkg::REG_KP_GAIN:        cfg.kp_gain        <= cfg_data[lfp_pkg::GAIN_W-1:0];
        lfp_pkg::REG_KI_GAIN:        cfg.ki_gain        <= cfg_data[lfp_pkg::GAIN_W-1:0];
        lfp_pkg::REG_KD_GAIN:        cfg.kd_gain        <= cfg_data[lfp_pkg::GAIN_W-1:0];
        lfp_pkg::REG_BASE_SPEED:     cfg.base_speed     <= cfg_data[lfp_pkg::SPEED_W-1:0];
        lfp_pkg::REG_TURN_SPEED:     cfg.turn_speed     <= cfg_data[lfp_pkg::SPEED_W-1:0];
        lfp_pkg::REG_DARK_LEVEL:     cfg.dark_level     <= cfg_data[lfp_pkg::READING_W-1:0];
        lfp_pkg::REG_SIDE_THRESHOLD: cfg.side_threshold <= cfg_data[lfp_pkg::READING_W-1:0];
        lfp_pkg::REG_SIDE_HOLD_MS:   cfg.side_hold_ms   <= cfg_data[lfp_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or the stage after it moves on.
  always_comb begin
    ready[STAGES-1] = !stage_valid[STAGES-1] || !result_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      ready[k] = !stage_valid[k] || ready[k+1];
    end
  end

  assign upstream = {stage_valid[STAGES-2:0], item_valid};
  assign load_vec = upstream & ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= (ready & upstream) | (~ready & stage_valid);
    end
  end

  assign load.in   = load_vec[0];
  assign load.step = load_vec[1];
  assign load.mul  = load_vec[2];
  assign load.acc  = load_vec[3];
  assign load.corr = load_vec[4];
  assign load.out  = load_vec[5];

  assign item_stall   = !ready[0];
  assign result_valid = stage_valid[STAGES-1];

  assign readings = {sensor_7, sensor_6, sensor_5, sensor_4,
                     sensor_3, sensor_2, sensor_1, sensor_0};

  lfp_state u_state (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .cfg      (cfg),
    .position (position),
    .readings (readings),
    .now_ms   (now_ms),
    .cmd      (cmd),
    .step     (step)
  );

  lfp_pid #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_pid (
    .clk  (clk),
    .load (load),
    .cfg  (cfg),
    .step (step),
    .corr (corr),
    .tag  (tag)
  );

  lfp_drive #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_drive (
    .clk         (clk),
    .load        (load),
    .cfg         (cfg),
    .corr        (corr),
    .tag         (tag),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .line_lost   (line_lost),
    .seen_side   (seen_side),
    .line_error  (line_error)
  );

  // Input back-pressure only when the whole pipeline is occupied.
  `LFP_ASSERT_IMPL(a_stall_full, clk, rst, item_stall, &stage_valid, "input stalled with a free stage")
  // A spin toward a lost line drives the wheels in opposite directions.
  `LFP_ASSERT_IMPL(a_spin_mirror, clk, rst, result_valid && line_lost && seen_side != lfp_pkg::SIDE_NONE && left_drive != 9'sd0 && (left_drive < 0 || right_drive < 0), left_drive == -right_drive, "spin drives not mirrored")

endmodule

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// Line follower PID step testbench
// Sends control ticks through the block and checks every drive result
// against a tick-by-tick software predictor of the controller. The run
// covers several register settings, including both ends of every range,
// and random idling and stalling on both sides. It also forces a long
// result hold-off that fills the pipeline and pauses the sender mid-run.
// ---------------------------------------------------------------------------
module tb;
  import lfp_pkg::*;

  localparam int GAIN_FRAC   = 16;
  localparam int PIPE_DEPTH  = 6;
  localparam int DRAIN_GAP   = PIPE_DEPTH + 4;
  localparam int HOLD_OFF    = 200;
  localparam int QUIET_LIMIT = 3000;

  // Command codes with no package name: keep, and the spare code that acts as keep.
  localparam logic [1:0] CMD_KEEP  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam longint SUM_HI = (64'sd1 <<< 31) - 1;
  localparam longint SUM_LO = -(64'sd1 <<< 31);

  typedef struct packed {
    logic [POS_W-1:0]  position;
    readings_t         reading;
    logic [TIME_W-1:0] stamp;
    logic [1:0]        cmd;
  } tick_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
    logic                      lost;
    side_t                     side;
    logic signed [ERR_W-1:0]   err;
  } drive_t;

  logic clk;
  logic rst = 1'b1;

  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  tick_t                on_wire      = '0;

  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;
  logic                      line_lost;
  logic [1:0]                seen_side;
  logic signed [ERR_W-1:0]   line_error;

  // Pending ticks, predicted drives and run bookkeeping.
  tick_t  tick_q[$];
  drive_t drive_q[$];
  int     ticks_queued = 0;
  int     ticks_in     = 0;
  int     drives_out   = 0;
  int     lost_ticks   = 0;
  int     spin_ticks   = 0;
  int     fails        = 0;
  int     quiet        = 0;
  bit     tick_taken   = 1'b0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     hold_req     = 1'b0;
  int     hold_left    = 0;
  logic [TIME_W-1:0] stamp_ms = '0;

  // Predictor copy of the registers.
  longint               kp_q     = longint'(RST_KP_GAIN);
  longint               ki_q     = longint'(RST_KI_GAIN);
  longint               kd_q     = longint'(RST_KD_GAIN);
  longint               base_q   = longint'(RST_BASE_SPEED);
  longint               turn_q   = longint'(RST_TURN_SPEED);
  logic [READING_W-1:0] lost_thr = RST_DARK_LEVEL;
  logic [READING_W-1:0] side_thr = RST_SIDE_THRESHOLD;
  logic [HOLD_W-1:0]    hold_ms  = RST_SIDE_HOLD_MS;

  // Predictor copy of the controller state.
  longint            prev_err   = 0;
  longint            err_sum    = 0;
  logic              running    = 1'b0;
  side_t             side_mem   = SIDE_NONE;
  logic [TIME_W-1:0] side_stamp = '0;

  line_follow_pid_step #(
    .GAIN_FRAC_BITS(GAIN_FRAC)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .position     (on_wire.position),
    .sensor_0     (on_wire.reading[0]),
    .sensor_1     (on_wire.reading[1]),
    .sensor_2     (on_wire.reading[2]),
    .sensor_3     (on_wire.reading[3]),
    .sensor_4     (on_wire.reading[4]),
    .sensor_5     (on_wire.reading[5]),
    .sensor_6     (on_wire.reading[6]),
    .sensor_7     (on_wire.reading[7]),
    .now_ms       (on_wire.stamp),
    .cmd          (on_wire.cmd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .left_drive   (left_drive),
    .right_drive  (right_drive),
    .line_lost    (line_lost),
    .seen_side    (seen_side),
    .line_error   (line_error),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One control tick: run command, side memory, lost test, PID and drives.
  function automatic drive_t pid_tick(tick_t t);
    longint            e, s, acc, corr, l, r;
    logic [TIME_W-1:0] since;
    logic              lost;
    int                i;
    drive_t            d;
    if (t.cmd == CMD_RUN) begin
      running = 1'b1;
      err_sum = 0;
    end else if (t.cmd == CMD_STOP) begin
      running = 1'b0;
    end

    since = t.stamp - side_stamp;
    if (t.reading[0] >= side_thr && t.reading[SENSOR_COUNT-1] < side_thr) begin
      if (side_mem != SIDE_LEFT && since >= TIME_W'(hold_ms)) begin
        side_mem   = SIDE_LEFT;
        side_stamp = t.stamp;
      end
    end else if (t.reading[0] < side_thr && t.reading[SENSOR_COUNT-1] >= side_thr) begin
      if (side_mem != SIDE_RIGHT && since >= TIME_W'(hold_ms)) begin
        side_mem   = SIDE_RIGHT;
        side_stamp = t.stamp;
      end
    end

    lost = 1'b1;
    for (i = 0; i < SENSOR_COUNT; i++)
      if (t.reading[i] > lost_thr) lost = 1'b0;

    // Position is saturated to the top of the range before the error.
    e = longint'(t.position);
    if (e > POS_MAX) e = POS_MAX;
    e = e - POS_CENTRE;

    s = err_sum + e;
    if (s > SUM_HI) s = SUM_HI;
    else if (s < SUM_LO) s = SUM_LO;
    err_sum = s;

    // Exact sum of products, then a shift that truncates toward zero.
    acc  = kp_q * e + kd_q * (e - prev_err) + ki_q * s;
    corr = (acc < 0) ? -((-acc) >>> GAIN_FRAC) : (acc >>> GAIN_FRAC);
    prev_err = e;

    l = base_q - corr;
    if (l < 0) l = 0;
    else if (l > base_q) l = base_q;
    r = base_q + corr;
    if (r < 0) r = 0;
    else if (r > base_q) r = base_q;

    if (!running) begin
      l = 0;
      r = 0;
    end else if (lost && side_mem == SIDE_RIGHT) begin
      l = -turn_q;
      r = turn_q;
    end else if (lost && side_mem == SIDE_LEFT) begin
      l = turn_q;
      r = -turn_q;
    end

    d.left  = l[DRIVE_W-1:0];
    d.right = r[DRIVE_W-1:0];
    d.lost  = lost;
    d.side  = side_mem;
    d.err   = e[ERR_W-1:0];
    return d;
  endfunction

  // Directed tick: outer readings given, the six inner ones share a value.
  function automatic tick_t mk_tick(int pos, int inner, int s0, int s7,
                                    logic [TIME_W-1:0] at, logic [1:0] c);
    tick_t t;
    int    i;
    t.position = POS_W'(pos);
    for (i = 1; i < SENSOR_COUNT - 1; i++) t.reading[i] = READING_W'(inner);
    t.reading[0]              = READING_W'(s0);
    t.reading[SENSOR_COUNT-1] = READING_W'(s7);
    t.stamp = at;
    t.cmd   = c;
    return t;
  endfunction

  // Random tick, mostly a plausible scan: time moving forward a little,
  // readings that often show the line at one edge or nowhere at all.
  function automatic tick_t rand_tick();
    tick_t t;
    int    pick;
    int    i;
    logic [READING_W-1:0] hi_rd, lo_rd;
    pick = $urandom_range(99);
    if (pick < 6) t.cmd = CMD_STOP;
    else if (pick < 16) t.cmd = CMD_RUN;
    else if (pick < 20) t.cmd = CMD_SPARE;
    else t.cmd = CMD_KEEP;

    pick = $urandom_range(99);
    if (pick < 85) stamp_ms += $urandom_range(80);
    else if (pick < 95) stamp_ms += $urandom_range(1000);
    else stamp_ms = $urandom;
    t.stamp = stamp_ms;

    if ($urandom_range(9) == 0) t.position = POS_W'($urandom_range(8191, POS_MAX + 1));
    else t.position = POS_W'($urandom_range(POS_MAX));

    pick = $urandom_range(99);
    for (i = 0; i < SENSOR_COUNT; i++) begin
      if (pick < 15) t.reading[i] = READING_W'($urandom_range(lost_thr));
      else if (pick < 25) t.reading[i] = READING_W'($urandom_range(1023));
      else t.reading[i] = READING_W'($urandom_range(1000));
    end
    if (pick >= 25 && pick < 45 && side_thr != 0 && side_thr <= 1000) begin
      hi_rd = READING_W'($urandom_range(1000, side_thr));
      lo_rd = READING_W'($urandom_range(side_thr - 1));
      if (pick < 35) begin
        t.reading[0]              = hi_rd;
        t.reading[SENSOR_COUNT-1] = lo_rd;
      end else begin
        t.reading[0]              = lo_rd;
        t.reading[SENSOR_COUNT-1] = hi_rd;
      end
    end
    return t;
  endfunction

  task automatic queue_tick(tick_t t);
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  task automatic queue_random(int n);
    int k;
    for (k = 0; k < n; k++) queue_tick(rand_tick());
  endtask

  // Register write on the port, mirrored into the predictor.
  task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_KP_GAIN:        kp_q     = longint'(val);
      REG_KI_GAIN:        ki_q     = longint'(val);
      REG_KD_GAIN:        kd_q     = longint'(val);
      REG_BASE_SPEED:     base_q   = longint'(val[SPEED_W-1:0]);
      REG_TURN_SPEED:     turn_q   = longint'(val[SPEED_W-1:0]);
      REG_DARK_LEVEL:     lost_thr = val[READING_W-1:0];
      REG_SIDE_THRESHOLD: side_thr = val[READING_W-1:0];
      REG_SIDE_HOLD_MS:   hold_ms  = val[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(int kp, int ki, int kd, int base, int turn,
                             int lost, int side, int hold);
    set_reg(REG_KP_GAIN, CFG_DATA_W'(kp));
    set_reg(REG_KI_GAIN, CFG_DATA_W'(ki));
    set_reg(REG_KD_GAIN, CFG_DATA_W'(kd));
    set_reg(REG_BASE_SPEED, CFG_DATA_W'(base));
    set_reg(REG_TURN_SPEED, CFG_DATA_W'(turn));
    set_reg(REG_DARK_LEVEL, CFG_DATA_W'(lost));
    set_reg(REG_SIDE_THRESHOLD, CFG_DATA_W'(side));
    set_reg(REG_SIDE_HOLD_MS, CFG_DATA_W'(hold));
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Wait until every queued tick has gone in and every drive has come out.
  task automatic wait_drained();
    while (ticks_in != ticks_queued || drive_q.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // Input side: hold a beat until it is taken, then offer the next or idle.
  always @(negedge clk) begin
    if (!rst && (!item_valid || tick_taken)) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        on_wire    <= tick_q.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Beats taken on either channel: predict on input, check on output.
  always @(posedge clk) begin
    drive_t want;
    tick_taken = 1'b0;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        tick_taken = 1'b1;
        drive_q.push_back(pid_tick(on_wire));
        ticks_in++;
      end
      if (result_valid && !result_stall) begin
        drives_out++;
        if (drive_q.size() == 0) begin
          $error("drive result arrived with none outstanding");
          fails++;
        end else begin
          want = drive_q.pop_front();
          if (want.lost) lost_ticks++;
          if (want.left < 0 || want.right < 0) spin_ticks++;
          if (left_drive !== want.left) begin
            $error("left_drive: expected %0d, got %0d", want.left, left_drive);
            fails++;
          end
          if (right_drive !== want.right) begin
            $error("right_drive: expected %0d, got %0d", want.right, right_drive);
            fails++;
          end
          if (line_lost !== want.lost) begin
            $error("line_lost: expected %0d, got %0d", want.lost, line_lost);
            fails++;
          end
          if (seen_side !== want.side) begin
            $error("seen_side: expected %0d, got %0d", want.side, seen_side);
            fails++;
          end
          if (line_error !== want.err) begin
            $error("line_error: expected %0d, got %0d", want.err, line_error);
            fails++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("line_follow_pid_step test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset register values, sender idles less than the receiver.
    load_config(RST_KP_GAIN, RST_KI_GAIN, RST_KD_GAIN, RST_BASE_SPEED,
                RST_TURN_SPEED, RST_DARK_LEVEL, RST_SIDE_THRESHOLD,
                RST_SIDE_HOLD_MS);
    set_idling(32, 62);

    // Line lost before any side is known: the PID drives apply.
    queue_tick(mk_tick(3500, 0, 0, 0, 32'd0, CMD_RUN));
    queue_tick(mk_tick(3500, 900, 900, 900, 32'd5, CMD_KEEP));
    queue_tick(mk_tick(0, 1000, 1000, 1000, 32'd10, CMD_KEEP));
    queue_tick(mk_tick(POS_MAX, 1000, 1000, 1000, 32'd15, CMD_KEEP));
    // Position beyond the range, including every bit set.
    queue_tick(mk_tick(8191, 900, 900, 900, 32'd20, CMD_KEEP));
    queue_tick(mk_tick(POS_MAX + 1, 900, 900, 900, 32'd25, CMD_KEEP));
    // Left edge seen exactly at the threshold; right edge blocked by the hold.
    queue_tick(mk_tick(1200, 500, 800, 799, 32'd200, CMD_KEEP));
    queue_tick(mk_tick(5800, 500, 0, 1000, 32'd250, CMD_KEEP));
    queue_tick(mk_tick(5800, 500, 0, 1000, 32'd400, CMD_KEEP));
    // Lost line with readings at and just above the lost threshold.
    queue_tick(mk_tick(6500, 0, 0, 0, 32'd410, CMD_KEEP));
    queue_tick(mk_tick(6500, 750, 750, 750, 32'd420, CMD_KEEP));
    queue_tick(mk_tick(6500, 750, 751, 750, 32'd430, CMD_KEEP));
    // Readings above the range on every sensor still see the line.
    queue_tick(mk_tick(3000, 1023, 1023, 1023, 32'd440, CMD_KEEP));
    queue_tick(mk_tick(900, 300, 1000, 0, 32'd600, CMD_KEEP));
    queue_tick(mk_tick(900, 100, 100, 100, 32'd610, CMD_SPARE));
    // Stopped: zero drives while the other fields still report.
    queue_tick(mk_tick(900, 100, 100, 100, 32'd620, CMD_STOP));
    queue_tick(mk_tick(4000, 900, 900, 900, 32'd630, CMD_KEEP));
    queue_tick(mk_tick(4000, 100, 100, 100, 32'd640, CMD_RUN));
    // Hold time measured across the wrap of the millisecond counter.
    queue_tick(mk_tick(2000, 500, 0, 900, 32'hFFFF_FFF0, CMD_KEEP));
    queue_tick(mk_tick(2000, 500, 900, 0, 32'h0000_0020, CMD_KEEP));
    queue_tick(mk_tick(2000, 500, 900, 0, 32'h0000_0080, CMD_KEEP));
    queue_tick(mk_tick(2000, 0, 0, 0, 32'h0000_0090, CMD_KEEP));
    stamp_ms = 32'h0000_0100;
    wait_drained();

    // Every register at the top of its range.
    load_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 255, 255, 1000, 1000, 65535);
    queue_random(200);
    wait_drained();

    // Every register at zero, receiver now idles less than the sender.
    load_config(0, 0, 0, 0, 0, 0, 0, 0);
    set_idling(62, 32);
    queue_random(150);
    wait_drained();

    // Mid-range gains; a long result hold-off fills the pipeline.
    load_config($urandom_range(4000), $urandom_range(50), $urandom_range(20000),
                $urandom_range(255, 128), $urandom_range(255),
                $urandom_range(900, 300), $urandom_range(1000, 500),
                $urandom_range(300));
    queue_random(350);
    hold_req = 1'b1;
    wait_drained();

    // Reset values again, no idling; the sender pauses half way through.
    load_config(RST_KP_GAIN, RST_KI_GAIN, RST_KD_GAIN, RST_BASE_SPEED,
                RST_TURN_SPEED, RST_DARK_LEVEL, RST_SIDE_THRESHOLD,
                RST_SIDE_HOLD_MS);
    set_idling(0, 0);
    queue_random(200);
    wait_drained();
    queue_random(200);
    wait_drained();

    if (drive_q.size() != 0) begin
      $error("%0d drive results never arrived", drive_q.size());
      fails++;
    end
    $display("Covered %0d ticks and %0d checked drive results over five register sets.",
             ticks_in, drives_out);
    $display("Line was lost on %0d ticks and the robot spun back on %0d of them.",
             lost_ticks, spin_ticks);
    if (fails == 0) begin
      $display("line_follow_pid_step test passed");
    end else begin
      $display("line_follow_pid_step test failed");
    end
    $finish;
  end

endmodule

@@ line_follow_pid_step.f @@
+incdir+rtl
rtl/lfp_pkg.sv
rtl/lfp_state.sv
rtl/lfp_pid.sv
rtl/lfp_drive.sv
rtl/line_follow_pid_step.sv
sim/tb.sv
